[rtl/core/ic3_pkg.sv]
// ----------------------------------------------------------------------------
// ic3_pkg
// Shared types and constants of the 3x3 image convolution core.
// ----------------------------------------------------------------------------
package ic3_pkg;

  // parameter defaults
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;
  localparam int COEF_BITS_DEF  = 16;

  // fixed field widths
  localparam int IN_PIX_W     = 8;
  localparam int OUT_W        = 16;
  localparam int KERNEL_W     = 48;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CHAN_REG_W   = 2;
  localparam int SHIFT_W      = 5;
  localparam int MAX_HEIGHT   = 4096;
  localparam int ROW_W        = 12;

  // configuration port
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 6;

  // result queue
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;
  localparam int FIFO_SLACK = 7;

  // register map, one register every 8 bytes
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH       = 3'd0,
    REG_IMAGE_HEIGHT      = 3'd1,
    REG_CHANNEL_COUNT     = 3'd2,
    REG_PRESERVE_CHANNELS = 3'd3,
    REG_KERNEL_TOP        = 3'd4,
    REG_KERNEL_MIDDLE     = 3'd5,
    REG_KERNEL_BOTTOM     = 3'd6,
    REG_OUT_SHIFT         = 3'd7
  } cfg_reg_t;

  // item kinds
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // register reset values
  localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH   = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT  = 13'd480;
  localparam logic [CHAN_REG_W-1:0]   RST_CHANNEL_COUNT = 2'd3;
  localparam logic [KERNEL_W-1:0]     RST_KERNEL_TOP    = 48'd0;
  localparam logic [KERNEL_W-1:0]     RST_KERNEL_MIDDLE = 48'd16777216;
  localparam logic [KERNEL_W-1:0]     RST_KERNEL_BOTTOM = 48'd0;
  localparam logic [SHIFT_W-1:0]      RST_OUT_SHIFT     = 5'd8;

  // control flags that travel with an item through the first stage
  typedef struct packed {
    logic pre_emit;    // result from the window before the shift
    logic post_emit;   // result from the window after the shift
    logic top_pre;     // clamp top row, pre-shift result
    logic top_post;    // clamp top row, post-shift result
    logic left_post;   // clamp left column, post-shift result
    logic top_last;    // clamp top row for the closing result
    logic w1;          // one-pixel-wide image
    logic dup;         // flush: repeat the middle line as the bottom row
    logic last;        // final flush transaction of the frame
    logic extra;       // closing result slot, no line store update
    logic frame_last;  // result carries the end-of-frame mark
  } s1_flags_t;

  // one result word in the output queue
  typedef struct packed {
    logic signed [OUT_W-1:0] out0;
    logic signed [OUT_W-1:0] out1;
    logic signed [OUT_W-1:0] out2;
    logic                    frame_last;
  } out_word_t;

endpackage

[rtl/core/ic3_if.sv]
// ----------------------------------------------------------------------------
// ic3_if
// Valid/ready stream channels of the convolution core: pixel input, results.
// ----------------------------------------------------------------------------
interface ic3_in_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic [ic3_pkg::IN_PIX_W-1:0]    chan0;
  logic [ic3_pkg::IN_PIX_W-1:0]    chan1;
  logic [ic3_pkg::IN_PIX_W-1:0]    chan2;

  modport source (output valid, func, chan0, chan1, chan2, input ready);
  modport sink   (input valid, func, chan0, chan1, chan2, output ready);
endinterface

interface ic3_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [ic3_pkg::OUT_W-1:0] out0;
  logic signed [ic3_pkg::OUT_W-1:0] out1;
  logic signed [ic3_pkg::OUT_W-1:0] out2;
  logic                            frame_last;

  modport source (output valid, out0, out1, out2, frame_last, input ready);
  modport sink   (input valid, out0, out1, out2, frame_last, output ready);
endinterface

[rtl/core/image_convolution_3x3_core.sv]
// ----------------------------------------------------------------------------
// image_convolution_3x3_core
// 3x3 correlation over a raster pixel stream, clamp-to-edge borders.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries raster-order pixels (func = pixel) of up to three channels,
//   then one flush transaction per column (func = flush) to drain the last
//   row. out_ch carries one result per pixel, frame_last on the final one.
//   Results lag the input by one row plus one pixel; the last flush
//   transaction yields two results.
//   Throughput: one transaction per cycle while the result queue has room. The
//   only other bubble is in the cycle after the last flush transaction of a
//   frame, where the closing result takes the first pipeline stage.
//   After the transaction that completes its window, a result passes line
//   store read, tap select, multiply, channel sum and final sum/shift/saturate
//   into a 16-entry result queue, which feeds out_ch.
//   When the receiver stalls, results collect in the queue and in_ch.ready
//   drops while fewer than seven entries are free; nothing is lost.
//   Reset (synchronous, active low) clears counters, window, queue and the
//   registers to their defaults, not the line stores. The APB-style port writes
//   registers at byte address 8*i; user writes only while idle (not enforced).
// ----------------------------------------------------------------------------
module image_convolution_3x3_core #(
  parameter int MAX_WIDTH  = ic3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = ic3_pkg::PIXEL_BITS_DEF,
  parameter int COEF_BITS  = ic3_pkg::COEF_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ic3_in_if.sink                     in_ch,
  ic3_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ic3_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [ic3_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [ic3_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int PW     = PIXEL_BITS;
  localparam int LW     = 3 * PW;
  localparam int KW     = 3 * COEF_BITS;
  localparam int CW     = 14;
  localparam int PROD_W = PW + 1 + COEF_BITS;
  localparam int ACC_W  = PROD_W + 4;
  localparam int TW     = ACC_W + 2;
  localparam int OUT_W  = ic3_pkg::OUT_W;
  localparam logic signed [TW-1:0] SAT_HI = TW'(32767);
  localparam logic signed [TW-1:0] SAT_LO = TW'(-32768);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [ic3_pkg::WIDTH_REG_W-1:0]  width_r;
  logic [ic3_pkg::HEIGHT_REG_W-1:0] height_r;
  logic [ic3_pkg::CHAN_REG_W-1:0]   chan_cnt_r;
  logic                             preserve_r;
  logic [ic3_pkg::KERNEL_W-1:0]     kern_r [3];
  logic [ic3_pkg::SHIFT_W-1:0]      shift_r;
  logic                             cfg_wr;
  ic3_pkg::cfg_reg_t                cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = ic3_pkg::cfg_reg_t'(cfg_paddr[5:3]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= ic3_pkg::RST_IMAGE_WIDTH;
      height_r   <= ic3_pkg::RST_IMAGE_HEIGHT;
      chan_cnt_r <= ic3_pkg::RST_CHANNEL_COUNT;
      preserve_r <= 1'b0;
      kern_r[0]  <= ic3_pkg::RST_KERNEL_TOP;
      kern_r[1]  <= ic3_pkg::RST_KERNEL_MIDDLE;
      kern_r[2]  <= ic3_pkg::RST_KERNEL_BOTTOM;
      shift_r    <= ic3_pkg::RST_OUT_SHIFT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ic3_pkg::REG_IMAGE_WIDTH:       width_r    <= cfg_pwdata[10:0];
        ic3_pkg::REG_IMAGE_HEIGHT:      height_r   <= cfg_pwdata[12:0];
        ic3_pkg::REG_CHANNEL_COUNT:     chan_cnt_r <= cfg_pwdata[1:0];
        ic3_pkg::REG_PRESERVE_CHANNELS: preserve_r <= cfg_pwdata[0];
        ic3_pkg::REG_KERNEL_TOP:        kern_r[0]  <= cfg_pwdata[47:0];
        ic3_pkg::REG_KERNEL_MIDDLE:     kern_r[1]  <= cfg_pwdata[47:0];
        ic3_pkg::REG_KERNEL_BOTTOM:     kern_r[2]  <= cfg_pwdata[47:0];
        ic3_pkg::REG_OUT_SHIFT:         shift_r    <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (cfg_idx)
      ic3_pkg::REG_IMAGE_WIDTH:       cfg_prdata = 64'(width_r);
      ic3_pkg::REG_IMAGE_HEIGHT:      cfg_prdata = 64'(height_r);
      ic3_pkg::REG_CHANNEL_COUNT:     cfg_prdata = 64'(chan_cnt_r);
      ic3_pkg::REG_PRESERVE_CHANNELS: cfg_prdata = 64'(preserve_r);
      ic3_pkg::REG_KERNEL_TOP:        cfg_prdata = 64'(kern_r[0]);
      ic3_pkg::REG_KERNEL_MIDDLE:     cfg_prdata = 64'(kern_r[1]);
      ic3_pkg::REG_KERNEL_BOTTOM:     cfg_prdata = 64'(kern_r[2]);
      ic3_pkg::REG_OUT_SHIFT:         cfg_prdata = 64'(shift_r);
      default:                        cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // effective geometry
  // --------------------------------------------------------------------------
  logic [AW:0]   eff_w;
  logic [AW-1:0] wm1;
  logic [12:0]   eff_h;
  logic [1:0]    eff_n;

  always_comb begin
    if (width_r == '0) begin
      eff_w = (AW+1)'(1);
    end else if (CW'(width_r) > CW'(MAX_WIDTH)) begin
      eff_w = (AW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (AW+1)'(width_r);
    end
    wm1 = AW'(eff_w - (AW+1)'(1));
    if (height_r == '0) begin
      eff_h = 13'd1;
    end else if (height_r > 13'(ic3_pkg::MAX_HEIGHT)) begin
      eff_h = 13'(ic3_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
    eff_n = (chan_cnt_r == 2'd0) ? 2'd1 : chan_cnt_r;
  end

  // --------------------------------------------------------------------------
  // position counters and input handshake
  // --------------------------------------------------------------------------
  logic [AW-1:0]            col_r, col_nxt;
  logic [AW-1:0]            flush_r, flush_nxt;
  logic [ic3_pkg::ROW_W-1:0] row_r, row_nxt;
  logic                     drain_r, drain_nxt;
  logic [ic3_pkg::FIFO_AW:0] fifo_cnt_r;
  logic                     s1_valid_r;
  ic3_pkg::s1_flags_t       s1_f_r;
  logic                     accept, take_pix, take_fl, take;
  logic [AW-1:0]            c_pix, c_fl, c_sel;
  logic                     col_end, row_end;
  logic [12:0]              r_sel;
  ic3_pkg::s1_flags_t       f_new;
  ic3_pkg::s1_flags_t       f_close;

  assign in_ch.ready = (fifo_cnt_r <= (ic3_pkg::FIFO_AW+1)'(ic3_pkg::FIFO_DEPTH
                        - ic3_pkg::FIFO_SLACK)) && !(s1_valid_r && s1_f_r.last);
  assign accept   = in_ch.valid && in_ch.ready;
  assign take_pix = accept && (in_ch.func == ic3_pkg::FUNC_PIXEL) && !drain_r;
  assign take_fl  = accept && (in_ch.func == ic3_pkg::FUNC_FLUSH) && drain_r;
  assign take     = take_pix || take_fl;

  // position of the accepted transaction
  always_comb begin
    c_pix   = (col_r > wm1) ? wm1 : col_r;
    c_fl    = (flush_r > wm1) ? wm1 : flush_r;
    c_sel   = drain_r ? c_fl : c_pix;
    col_end = ((AW+1)'(c_sel) + (AW+1)'(1)) >= eff_w;
    row_end = (13'(row_r) + 13'd1) >= eff_h;
    r_sel   = drain_r ? eff_h : 13'(row_r);

    f_new.pre_emit   = (c_sel == '0) && (r_sel >= 13'd2);
    f_new.post_emit  = (c_sel != '0) && (r_sel >= 13'd1);
    f_new.top_pre    = (r_sel == 13'd2);
    f_new.top_post   = (r_sel == 13'd1);
    f_new.left_post  = (c_sel == AW'(1));
    f_new.top_last   = (eff_h == 13'd1);
    f_new.w1         = (eff_w == (AW+1)'(1));
    f_new.dup        = drain_r;
    f_new.last       = drain_r && col_end;
    f_new.extra      = 1'b0;
    f_new.frame_last = 1'b0;
  end

  // flags of the closing result slot
  always_comb begin
    f_close            = '0;
    f_close.pre_emit   = 1'b1;
    f_close.top_pre    = s1_f_r.top_last;
    f_close.w1         = s1_f_r.w1;
    f_close.extra      = 1'b1;
    f_close.frame_last = 1'b1;
  end

  // counter update
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    flush_nxt = flush_r;
    drain_nxt = drain_r;
    if (take_pix) begin
      if (col_end) begin
        col_nxt = '0;
        if (row_end) begin
          row_nxt   = '0;
          drain_nxt = 1'b1;
          flush_nxt = '0;
        end else begin
          row_nxt = row_r + ic3_pkg::ROW_W'(1);
        end
      end else begin
        col_nxt = c_pix + AW'(1);
      end
    end else if (take_fl) begin
      if (col_end) begin
        drain_nxt = 1'b0;
        flush_nxt = '0;
        row_nxt   = '0;
        col_nxt   = '0;
      end else begin
        flush_nxt = c_fl + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      flush_r <= '0;
      drain_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      flush_r <= flush_nxt;
      drain_r <= drain_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // line stores: upper and middle line share one RAM word per column
  // --------------------------------------------------------------------------
  logic              ram_we;
  logic [AW-1:0]     s1_col_r;
  logic [2*LW-1:0]   ram_wdata, ram_rdata, fwd_r, rd_word;
  logic              byp_r;

  ic3_ram #(
    .WIDTH (2 * LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .raddr (c_sel),
    .rdata (ram_rdata)
  );

  // forward a write that lands on the column read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= take && ram_we && (c_sel == s1_col_r);
    end
    fwd_r <= ram_wdata;
  end

  // --------------------------------------------------------------------------
  // stage 1: line store update, window shift, tap select
  // --------------------------------------------------------------------------
  logic [PW-1:0]      s1_pix_r [3];
  logic [PW-1:0]      up_px [3], mid_px [3], bot_px [3];
  logic [PW-1:0]      win_r [3][3][3];  // [column, 0 oldest][row, 0 top][channel]
  logic [PW-1:0]      win_nxt [3][3][3];
  logic [PW-1:0]      tap_nxt [3][3][3]; // [kernel row][kernel column][channel]
  logic [1:0]         col_idx [3];
  logic [1:0]         row_idx [3];
  logic               s2_valid_nxt;

  assign rd_word = byp_r ? fwd_r : ram_rdata;
  assign ram_we  = s1_valid_r && !s1_f_r.extra;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      up_px[ch]  = rd_word[LW + ch*PW +: PW];
      mid_px[ch] = rd_word[ch*PW +: PW];
      bot_px[ch] = s1_f_r.dup ? mid_px[ch] : s1_pix_r[ch];
      ram_wdata[LW + ch*PW +: PW] = mid_px[ch];
      ram_wdata[ch*PW +: PW]      = bot_px[ch];
    end
  end

  // window shift with the new column
  always_comb begin
    win_nxt = win_r;
    if (ram_we) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int rw = 0; rw < 3; rw++) begin
          win_nxt[0][rw][ch] = win_r[1][rw][ch];
          win_nxt[1][rw][ch] = win_r[2][rw][ch];
        end
        win_nxt[2][0][ch] = up_px[ch];
        win_nxt[2][1][ch] = mid_px[ch];
        win_nxt[2][2][ch] = bot_px[ch];
      end
    end
  end

  // clamped tap selection
  always_comb begin
    if (s1_f_r.post_emit) begin
      row_idx[0] = s1_f_r.top_post ? 2'd1 : 2'd0;
      col_idx[0] = s1_f_r.left_post ? 2'd1 : 2'd0;
      col_idx[1] = 2'd1;
    end else begin
      row_idx[0] = s1_f_r.top_pre ? 2'd1 : 2'd0;
      col_idx[0] = s1_f_r.w1 ? 2'd2 : 2'd1;
      col_idx[1] = 2'd2;
    end
    row_idx[1] = 2'd1;
    row_idx[2] = 2'd2;
    col_idx[2] = 2'd2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int ch = 0; ch < 3; ch++) begin
          tap_nxt[i][j][ch] = s1_f_r.post_emit ? win_nxt[col_idx[j]][row_idx[i]][ch]
                                               : win_r[col_idx[j]][row_idx[i]][ch];
        end
      end
    end
    s2_valid_nxt = s1_valid_r && (s1_f_r.pre_emit || s1_f_r.post_emit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        for (int rw = 0; rw < 3; rw++) begin
          for (int ch = 0; ch < 3; ch++) begin
            win_r[c][rw][ch] <= '0;
          end
        end
      end
    end else begin
      win_r <= win_nxt;
    end
  end

  // stage 1 load: accepted transaction or the closing result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_f_r     <= '0;
    end else if (take) begin
      s1_valid_r <= 1'b1;
      s1_f_r     <= f_new;
    end else if (s1_valid_r && s1_f_r.last) begin
      s1_valid_r <= 1'b1;
      s1_f_r     <= f_close;
    end else begin
      s1_valid_r <= 1'b0;
      s1_f_r     <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_col_r    <= c_sel;
      s1_pix_r[0] <= PW'(in_ch.chan0);
      s1_pix_r[1] <= PW'(in_ch.chan1);
      s1_pix_r[2] <= PW'(in_ch.chan2);
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: taps, products into stage 3
  // --------------------------------------------------------------------------
  logic                        s2_valid_r, s2_last_r;
  logic [PW-1:0]               s2_tap_r [3][3][3];
  logic [KW-1:0]               kext [3];
  logic signed [COEF_BITS-1:0] coef [3][3];
  logic signed [PROD_W-1:0]    prod_nxt [3][3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
    s2_last_r <= s1_f_r.frame_last;
    s2_tap_r  <= tap_nxt;
  end

  // signed coefficients, kernel column 0 in the low bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      kext[i] = KW'(kern_r[i]);
      for (int j = 0; j < 3; j++) begin
        coef[i][j] = $signed(kext[i][j*COEF_BITS +: COEF_BITS]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int ch = 0; ch < 3; ch++) begin
          prod_nxt[i][j][ch] = PROD_W'($signed({1'b0, s2_tap_r[i][j][ch]}))
                               * PROD_W'(coef[i][j]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: products, channel sums into stage 4
  // --------------------------------------------------------------------------
  logic                     s3_valid_r, s3_last_r;
  logic signed [PROD_W-1:0] s3_prod_r [3][3][3];
  logic signed [ACC_W-1:0]  acc_nxt [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_last_r <= s2_last_r;
    s3_prod_r <= prod_nxt;
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc_nxt[ch] = '0;
      for (int k = 0; k < 9; k++) begin
        acc_nxt[ch] = acc_nxt[ch] + ACC_W'(s3_prod_r[k/3][k%3][ch]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: channel sums, mode select, shift and saturate
  // --------------------------------------------------------------------------
  logic                    s4_valid_r, s4_last_r;
  logic signed [ACC_W-1:0] s4_acc_r [3];
  logic signed [TW-1:0]    total;
  ic3_pkg::out_word_t      res_word;

  function automatic logic signed [OUT_W-1:0] shift_sat(
    input logic signed [TW-1:0]            v,
    input logic [ic3_pkg::SHIFT_W-1:0]     sh
  );
    logic signed [TW-1:0] s;
    s = v >>> sh;
    if (s > SAT_HI) begin
      return OUT_W'(SAT_HI);
    end else if (s < SAT_LO) begin
      return OUT_W'(SAT_LO);
    end
    return OUT_W'(s);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
    s4_last_r <= s3_last_r;
    s4_acc_r  <= acc_nxt;
  end

  always_comb begin
    total = TW'(s4_acc_r[0])
          + ((eff_n >= 2'd2) ? TW'(s4_acc_r[1]) : '0)
          + ((eff_n == 2'd3) ? TW'(s4_acc_r[2]) : '0);
    res_word.frame_last = s4_last_r;
    if (preserve_r) begin
      res_word.out0 = shift_sat(TW'(s4_acc_r[0]), shift_r);
      res_word.out1 = (eff_n >= 2'd2) ? shift_sat(TW'(s4_acc_r[1]), shift_r) : '0;
      res_word.out2 = (eff_n == 2'd3) ? shift_sat(TW'(s4_acc_r[2]), shift_r) : '0;
    end else begin
      res_word.out0 = shift_sat(total, shift_r);
      res_word.out1 = '0;
      res_word.out2 = '0;
    end
  end

  // --------------------------------------------------------------------------
  // result queue
  // --------------------------------------------------------------------------
  ic3_pkg::out_word_t         fifo_r [ic3_pkg::FIFO_DEPTH];
  logic [ic3_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic                       pop;
  ic3_pkg::out_word_t         head;

  assign pop              = out_ch.valid && out_ch.ready;
  assign head             = fifo_r[rd_ptr_r];
  assign out_ch.valid     = (fifo_cnt_r != '0);
  assign out_ch.out0      = head.out0;
  assign out_ch.out1      = head.out1;
  assign out_ch.out2      = head.out2;
  assign out_ch.frame_last = head.frame_last;

  always_ff @(posedge clk) begin
    if (s4_valid_r) begin
      fifo_r[wr_ptr_r] <= res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (s4_valid_r) begin
        wr_ptr_r <= wr_ptr_r + ic3_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + ic3_pkg::FIFO_AW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + (ic3_pkg::FIFO_AW+1)'(s4_valid_r)
                               - (ic3_pkg::FIFO_AW+1)'(pop);
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= (ic3_pkg::FIFO_AW+1)'(ic3_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_closing_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_f_r.last) |=> (s1_valid_r && s1_f_r.extra && !ram_we))
    else $error("closing result slot missing after last flush");

  a_no_take_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_f_r.last) |-> !take)
    else $error("transaction taken while closing result is pending");

  a_frame_last_path: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_f_r.extra) |-> ##3 (s4_valid_r && s4_last_r))
    else $error("closing result lost in the pipeline");

endmodule

[rtl/core/ic3_ram.sv]
// ----------------------------------------------------------------------------
// ic3_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ic3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

[tb/sv/image_convolution_3x3_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// image_convolution_3x3_core_tb
// Self-checking testbench of the 3x3 image convolution core.
// Whole frames are streamed through the core under several register settings.
// A behavioral model of the line stores and window predicts every result,
// and each result on the output channel is checked in order against it.
// ----------------------------------------------------------------------------
module image_convolution_3x3_core_tb;

  typedef struct {
    logic       func;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
  } pix_item_t;

  logic clk;
  logic rst_n;
  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [ic3_pkg::CFG_AW-1:0]   cfg_paddr;
  logic [ic3_pkg::CFG_DW-1:0]   cfg_pwdata;
  logic [ic3_pkg::CFG_DW-1:0]   cfg_prdata;
  logic                         cfg_pready;

  ic3_in_if  in_bus ();
  ic3_out_if out_bus ();

  image_convolution_3x3_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pix_item_t           pending_pixels[$];
  ic3_pkg::out_word_t  expected_results[$];
  int                  mismatches = 0;
  int                  idle_phase = 0;

  // register copies
  logic [10:0] cur_width;
  logic [12:0] cur_height;
  logic [1:0]  cur_chans;
  logic        cur_preserve;
  logic [47:0] cur_kernel[3];
  logic [4:0]  cur_shift;

  // line stores, window [column][row][channel], raster counters
  logic [7:0] upper_ln[1024][3];
  logic [7:0] middle_ln[1024][3];
  logic [7:0] win[3][3][3];
  int         row_pos, col_pos, flush_pos;
  bit         draining;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // timeout
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int width_eff();
    if (cur_width == 0) return 1;
    if (cur_width > 1024) return 1024;
    return int'(cur_width);
  endfunction

  function automatic int height_eff();
    if (cur_height == 0) return 1;
    if (cur_height > 4096) return 4096;
    return int'(cur_height);
  endfunction

  function automatic longint kcoef(int i, int j);
    logic signed [15:0] c;
    c = cur_kernel[i][j*16 +: 16];
    return longint'(c);
  endfunction

  // arithmetic shift then 16-bit saturation
  function automatic logic [15:0] shift_saturate(longint v);
    longint r;
    r = v >>> cur_shift;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic void push_result(int top, int lc, int cc, int rc, bit fl);
    longint             acc[3];
    longint             total;
    int                 rows[3];
    int                 cols[3];
    int                 n;
    ic3_pkg::out_word_t w;
    n = (cur_chans == 0) ? 1 : int'(cur_chans);
    rows[0] = top; rows[1] = 1; rows[2] = 2;
    cols[0] = lc;  cols[1] = cc; cols[2] = rc;
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          acc[ch] += kcoef(i, j) * longint'(win[cols[j]][rows[i]][ch]);
    end
    if (cur_preserve) begin
      w.out0 = shift_saturate(acc[0]);
      w.out1 = (n > 1) ? shift_saturate(acc[1]) : 16'd0;
      w.out2 = (n > 2) ? shift_saturate(acc[2]) : 16'd0;
    end else begin
      total = 0;
      for (int ch = 0; ch < n; ch++) total += acc[ch];
      w.out0 = shift_saturate(total);
      w.out1 = '0;
      w.out2 = '0;
    end
    w.frame_last = fl;
    expected_results.push_back(w);
  endfunction

  // one pixel through the line stores and window
  function automatic void feed_pixel(int r, int c, logic [7:0] pix[3], bit dup);
    logic [7:0] u[3], m[3], p[3];
    int w;
    w = width_eff();
    if (c >= 1024) c = 1023;
    for (int ch = 0; ch < 3; ch++) begin
      u[ch] = upper_ln[c][ch];
      m[ch] = middle_ln[c][ch];
      p[ch] = dup ? m[ch] : pix[ch];
      upper_ln[c][ch]  = m[ch];
      middle_ln[c][ch] = p[ch];
    end
    if (c == 0 && r >= 2)
      push_result((r == 2) ? 1 : 0, (w == 1) ? 2 : 1, 2, 2, 1'b0);
    win[0] = win[1];
    win[1] = win[2];
    for (int ch = 0; ch < 3; ch++) begin
      win[2][0][ch] = u[ch];
      win[2][1][ch] = m[ch];
      win[2][2][ch] = p[ch];
    end
    if (c >= 1 && r >= 1)
      push_result((r == 1) ? 1 : 0, (c == 1) ? 1 : 0, 1, 2, 1'b0);
  endfunction

  // expected results of one accepted transaction
  function automatic void predict_transaction(pix_item_t it);
    int w, h;
    logic [7:0] pix[3];
    w = width_eff();
    h = height_eff();
    pix[0] = it.c0; pix[1] = it.c1; pix[2] = it.c2;
    if (it.func == ic3_pkg::FUNC_PIXEL) begin
      if (draining) return;
      if (col_pos >= w) col_pos = w - 1;
      feed_pixel(row_pos, col_pos, pix, 1'b0);
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        if (row_pos + 1 >= h) begin
          row_pos = 0;
          draining = 1'b1;
          flush_pos = 0;
        end else begin
          row_pos++;
        end
      end else begin
        col_pos++;
      end
    end else begin
      if (!draining) return;
      if (flush_pos >= w) flush_pos = w - 1;
      feed_pixel(h, flush_pos, pix, 1'b1);
      if (flush_pos + 1 >= w) begin
        push_result((h == 1) ? 1 : 0, (w == 1) ? 2 : 1, 2, 2, 1'b1);
        draining = 1'b0;
        flush_pos = 0;
        row_pos = 0;
        col_pos = 0;
      end else begin
        flush_pos++;
      end
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    int idle_pct;
    idle_pct = (idle_phase == 0) ? 13 : (idle_phase == 1) ? 87 : 0;
    if (rst_n && (!in_bus.valid || in_bus.ready)) begin
      if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        pix_item_t it;
        it = pending_pixels.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.func  <= it.func;
        in_bus.chan0 <= it.c0;
        in_bus.chan1 <= it.c1;
        in_bus.chan2 <= it.c2;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // result receiver stalls
  always @(posedge clk) begin
    int idle_pct;
    idle_pct = (idle_phase == 0) ? 87 : (idle_phase == 1) ? 13 : 0;
    out_bus.ready <= rst_n && ($urandom_range(0, 99) >= idle_pct);
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    pix_item_t          it;
    ic3_pkg::out_word_t want;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      it.func = in_bus.func;
      it.c0 = in_bus.chan0;
      it.c1 = in_bus.chan1;
      it.c2 = in_bus.chan2;
      predict_transaction(it);
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result out0=%0d out1=%0d out2=%0d last=%0b",
                   out_bus.out0, out_bus.out1, out_bus.out2, out_bus.frame_last);
      end else begin
        want = expected_results.pop_front();
        if (out_bus.out0 !== want.out0 || out_bus.out1 !== want.out1 ||
            out_bus.out2 !== want.out2 || out_bus.frame_last !== want.frame_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %0d %0d last=%0b got %0d %0d %0d last=%0b",
                     want.out0, want.out1, want.out2, want.frame_last,
                     out_bus.out0, out_bus.out1, out_bus.out2, out_bus.frame_last);
        end
      end
    end
  end

  // register write, setup then access
  task automatic write_reg(ic3_pkg::cfg_reg_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      ic3_pkg::REG_IMAGE_WIDTH:       cur_width    = value[10:0];
      ic3_pkg::REG_IMAGE_HEIGHT:      cur_height   = value[12:0];
      ic3_pkg::REG_CHANNEL_COUNT:     cur_chans    = value[1:0];
      ic3_pkg::REG_PRESERVE_CHANNELS: cur_preserve = value[0];
      ic3_pkg::REG_KERNEL_TOP:        cur_kernel[0] = value[47:0];
      ic3_pkg::REG_KERNEL_MIDDLE:     cur_kernel[1] = value[47:0];
      ic3_pkg::REG_KERNEL_BOTTOM:     cur_kernel[2] = value[47:0];
      ic3_pkg::REG_OUT_SHIFT:         cur_shift    = value[4:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int w, int h, int ch, bit pres,
                            logic [47:0] k0, logic [47:0] k1, logic [47:0] k2, int sh);
    write_reg(ic3_pkg::REG_IMAGE_WIDTH, 64'(w));
    write_reg(ic3_pkg::REG_IMAGE_HEIGHT, 64'(h));
    write_reg(ic3_pkg::REG_CHANNEL_COUNT, 64'(ch));
    write_reg(ic3_pkg::REG_PRESERVE_CHANNELS, 64'(pres));
    write_reg(ic3_pkg::REG_KERNEL_TOP, 64'(k0));
    write_reg(ic3_pkg::REG_KERNEL_MIDDLE, 64'(k1));
    write_reg(ic3_pkg::REG_KERNEL_BOTTOM, 64'(k2));
    write_reg(ic3_pkg::REG_OUT_SHIFT, 64'(sh));
  endtask

  // wait until every transaction is sent and every result is back
  task automatic wait_drained();
    while (pending_pixels.size() > 0 || in_bus.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_pix();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [47:0] rand_kernel_row();
    logic [47:0] k;
    case ($urandom_range(0, 2))
      0: k = 48'({$urandom, $urandom});
      1: begin
        for (int j = 0; j < 3; j++) k[j*16 +: 16] = 16'($signed($urandom_range(0, 1024)) - 512);
      end
      default: k = {16'h0000, 16'h0100, 16'h0000};
    endcase
    return k;
  endfunction

  // one frame of raster pixels plus the flush sequence, with optional noise
  task automatic queue_frame(int noise);
    pix_item_t it;
    int w, h;
    w = width_eff();
    h = height_eff();
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        if (noise > 0 && $urandom_range(0, 99) < noise) begin
          it.func = ic3_pkg::FUNC_FLUSH;
          it.c0 = rand_pix(); it.c1 = rand_pix(); it.c2 = rand_pix();
          pending_pixels.push_back(it);
        end
        it.func = ic3_pkg::FUNC_PIXEL;
        it.c0 = rand_pix(); it.c1 = rand_pix(); it.c2 = rand_pix();
        pending_pixels.push_back(it);
      end
    for (int c = 0; c < w; c++) begin
      it.func = ic3_pkg::FUNC_FLUSH;
      it.c0 = rand_pix(); it.c1 = rand_pix(); it.c2 = rand_pix();
      pending_pixels.push_back(it);
      if (noise > 0 && c < w - 1 && $urandom_range(0, 99) < noise) begin
        it.func = ic3_pkg::FUNC_PIXEL;
        it.c0 = rand_pix(); it.c1 = rand_pix(); it.c2 = rand_pix();
        pending_pixels.push_back(it);
      end
    end
  endtask

  task automatic random_config(int w, int h);
    set_config(w, h, $urandom_range(0, 3), 1'($urandom_range(0, 1)), rand_kernel_row(),
               rand_kernel_row(), rand_kernel_row(),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(5, 11));
  endtask

  // stimulus
  initial begin
    int planned;
    in_bus.valid = 1'b0;
    in_bus.func  = ic3_pkg::FUNC_PIXEL;
    in_bus.chan0 = '0;
    in_bus.chan1 = '0;
    in_bus.chan2 = '0;
    out_bus.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cur_width = ic3_pkg::RST_IMAGE_WIDTH;
    cur_height = ic3_pkg::RST_IMAGE_HEIGHT;
    cur_chans = ic3_pkg::RST_CHANNEL_COUNT;
    cur_preserve = 1'b0;
    cur_kernel[0] = ic3_pkg::RST_KERNEL_TOP;
    cur_kernel[1] = ic3_pkg::RST_KERNEL_MIDDLE;
    cur_kernel[2] = ic3_pkg::RST_KERNEL_BOTTOM;
    cur_shift = ic3_pkg::RST_OUT_SHIFT;
    for (int c = 0; c < 1024; c++)
      for (int ch = 0; ch < 3; ch++) begin
        upper_ln[c][ch] = '0;
        middle_ln[c][ch] = '0;
      end
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        for (int ch = 0; ch < 3; ch++) win[a][b][ch] = '0;
    row_pos = 0; col_pos = 0; flush_pos = 0; draining = 1'b0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: coefficient extremes with no shift, saturating both ways,
    // plus a flush before the frame is complete and a pixel while draining
    set_config(3, 3, 3, 1'b1, {16'h7FFF, 16'h8000, 16'h0100},
               {16'h0001, 16'h0100, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h0002}, 0);
    queue_frame(15);
    wait_drained();
    // one-pixel image, zero channel count, largest shift
    set_config(1, 1, 0, 1'b0, 48'hFFFF_FFFF_FFFF, 48'h7FFF_7FFF_7FFF,
               48'h8000_8000_8000, 31);
    queue_frame(0);
    wait_drained();
    set_config(2, 2, 2, 1'b0, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(), 8);
    queue_frame(0);
    wait_drained();

    // random frames, mostly small
    planned = 0;
    while (planned < 820) begin
      int w, h;
      idle_phase = (planned < 270) ? 0 : (planned < 540) ? 1 : 2;
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      random_config(w, h);
      queue_frame(($urandom_range(0, 3) == 0) ? 6 : 0);
      planned += w * h + w;
      wait_drained();
    end

    // zero geometry reads as one
    idle_phase = 2;
    random_config(0, 0);
    queue_frame(0);
    wait_drained();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
